FILE: rtl/core/mbtcp_pkg.sv
// Shared types and constants of the Modbus TCP holding register read server.
package mbtcp_pkg;

    localparam int BANK_WORDS    = 4096;
    localparam int BANK_AW       = $clog2(BANK_WORDS);
    localparam int MAX_ADU_BYTES = 260;
    localparam int MAX_LENGTH    = MAX_ADU_BYTES - 6;
    localparam int HDR_LAST      = 6;

    localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0] EXC_FLAG          = 8'h80;
    localparam logic [7:0] EXC_NONE          = 8'h00;
    localparam logic [7:0] EXC_ILLEGAL_FUNC  = 8'h01;
    localparam logic [7:0] EXC_ILLEGAL_ADDR  = 8'h02;
    localparam logic [7:0] EXC_ILLEGAL_VALUE = 8'h03;
    localparam logic [7:0] EXC_DEVICE_FAIL   = 8'h04;
    localparam logic [7:0] EXC_GATEWAY       = 8'h0B;

    typedef enum logic [1:0] {
        REQ_BYTE  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_CONN  = 2'd2,
        REQ_NONE  = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        CFG_STRICT   = 2'd0,
        CFG_UNIT     = 2'd1,
        CFG_MAXCOUNT = 2'd2,
        CFG_BANK     = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        SEL_HDR  = 2'd0,
        SEL_WHI  = 2'd1,
        SEL_WLO  = 2'd2,
        SEL_ZERO = 2'd3
    } byte_sel_t;

    typedef struct packed {
        logic      push;
        byte_sel_t sel;
        logic      last;
        logic      close;
        logic      clear;
    } mbtcp_cmd_t;

    typedef struct packed {
        logic ev_close;
        logic ev_answer;
        logic out_free;
        logic is_exc;
        logic hdr_done;
        logic words_done;
    } mbtcp_status_t;

endpackage

FILE: rtl/core/mbtcp_ram.sv
// Generic single port RAM with registered read data.
module mbtcp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/mbtcp_ctrl.sv
// Controller state machine that sequences close results and responses.
module mbtcp_ctrl
    import mbtcp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_fire,
    input  mbtcp_status_t status,
    output mbtcp_cmd_t    cmd,
    output logic          in_ready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_HDR,
        ST_RD,
        ST_HI,
        ST_LO
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '{push: 1'b0, sel: SEL_ZERO, last: 1'b0, close: 1'b0, clear: 1'b0};
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && status.ev_close)
                begin
                    state_next = ST_CLOSE;
                end
                else if (in_fire && status.ev_answer)
                begin
                    state_next = ST_HDR;
                end
            end
            ST_CLOSE:
            begin
                if (status.out_free)
                begin
                    cmd.close  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_HDR:
            begin
                if (status.out_free)
                begin
                    cmd.push = 1'b1;
                    cmd.sel  = SEL_HDR;
                    if (status.hdr_done)
                    begin
                        if (status.is_exc)
                        begin
                            cmd.last   = 1'b1;
                            cmd.clear  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_RD;
                        end
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_HI;
            end
            ST_HI:
            begin
                if (status.out_free)
                begin
                    cmd.push   = 1'b1;
                    cmd.sel    = SEL_WHI;
                    state_next = ST_LO;
                end
            end
            ST_LO:
            begin
                if (status.out_free)
                begin
                    cmd.push = 1'b1;
                    cmd.sel  = SEL_WLO;
                    if (status.words_done)
                    begin
                        cmd.last   = 1'b1;
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign in_ready = in_ready_reg;

endmodule

FILE: rtl/core/mbtcp_dp.sv
// Datapath: stream parser, configuration, register bank and chunk assembly.
module mbtcp_dp
    import mbtcp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_fire,
    input  logic [1:0]    req_type,
    input  logic [7:0]    rx_byte,
    input  logic [15:0]   bank_address,
    input  logic [15:0]   bank_data,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [7:0]    cfg_data,
    input  mbtcp_cmd_t    cmd,
    output mbtcp_status_t status,
    input  logic          out_ready,
    output logic          out_valid,
    output logic [63:0]   out_data,
    output logic [3:0]    out_bytes,
    output logic          last_chunk,
    output logic          close_conn
);

    logic        strict_reg, bank_att_reg;
    logic [7:0]  own_unit_reg;
    logic [6:0]  max_count_reg;

    logic [8:0]  pos_reg;
    logic [15:0] trans_reg, proto_reg, length_reg, start_reg, count_reg;
    logic [7:0]  unit_reg, func_reg;

    logic [3:0]  hidx_reg;
    logic [6:0]  widx_reg;
    logic [63:0] asm_reg;
    logic [2:0]  fill_reg;

    logic        out_valid_reg, out_last_reg, out_close_reg;
    logic [63:0] out_data_reg;
    logic [3:0]  out_bytes_reg;

    logic        is_byte, ev_close, ev_answer, ram_we;
    logic [16:0] end_addr, pos_inc, len_end;
    logic [7:0]  exc_code, push_byte, hdr_byte;
    logic [8:0]  plen;
    logic [15:0] rdata;
    logic [BANK_AW-1:0] ram_addr;
    logic [63:0] asm_next;
    logic [3:0]  fill_inc;
    logic        flush;

    assign is_byte   = in_fire && (req_type_t'(req_type) == REQ_BYTE);
    assign ev_close  = is_byte && (pos_reg == 9'(HDR_LAST)) &&
                       ((proto_reg != 16'd0) || (length_reg < 16'd2) ||
                        (length_reg > 16'(MAX_LENGTH)));
    assign pos_inc   = {8'd0, pos_reg} + 17'd1;
    assign len_end   = {1'b0, length_reg} + 17'd6;
    assign ev_answer = is_byte && (pos_reg > 9'(HDR_LAST)) && (pos_inc >= len_end);

    // Exception code from the finished request, checked in protocol order.
    assign end_addr = {1'b0, start_reg} + {1'b0, count_reg};
    always_comb
    begin
        if (strict_reg && (unit_reg != own_unit_reg))
            exc_code = EXC_GATEWAY;
        else if (func_reg != FUNC_READ_HOLDING)
            exc_code = EXC_ILLEGAL_FUNC;
        else if (length_reg != 16'd6)
            exc_code = EXC_ILLEGAL_VALUE;
        else if ((count_reg == 16'd0) || (count_reg > {9'd0, max_count_reg}))
            exc_code = EXC_ILLEGAL_VALUE;
        else if (end_addr > 17'h10000)
            exc_code = EXC_ILLEGAL_ADDR;
        else if (!bank_att_reg)
            exc_code = EXC_DEVICE_FAIL;
        else if (end_addr > 17'(BANK_WORDS))
            exc_code = EXC_ILLEGAL_ADDR;
        else
            exc_code = EXC_NONE;
    end

    assign plen = (exc_code != EXC_NONE) ? 9'd3 : (9'd3 + {1'b0, count_reg[6:0], 1'b0});

    always_comb
    begin
        case (hidx_reg)
            4'd0: hdr_byte = trans_reg[15:8];
            4'd1: hdr_byte = trans_reg[7:0];
            4'd4: hdr_byte = {7'd0, plen[8]};
            4'd5: hdr_byte = plen[7:0];
            4'd6: hdr_byte = unit_reg;
            4'd7: hdr_byte = (exc_code != EXC_NONE) ? (func_reg | EXC_FLAG)
                                                    : FUNC_READ_HOLDING;
            4'd8: hdr_byte = (exc_code != EXC_NONE) ? exc_code
                                                    : {count_reg[6:0], 1'b0};
            default: hdr_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        case (cmd.sel)
            SEL_HDR: push_byte = hdr_byte;
            SEL_WHI: push_byte = rdata[15:8];
            SEL_WLO: push_byte = rdata[7:0];
            default: push_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        asm_next = asm_reg;
        for (int j = 0; j < 8; j++)
        begin
            if (fill_reg == 3'(j))
                asm_next[63-8*j -: 8] = push_byte;
        end
    end
    assign fill_inc = {1'b0, fill_reg} + 4'd1;
    assign flush    = cmd.push && (cmd.last || (fill_inc == 4'd8));

    // The bank is written only while idle and read only during a response.
    assign ram_we   = in_fire && (req_type_t'(req_type) == REQ_WRITE) &&
                      (bank_address < 16'(BANK_WORDS));
    assign ram_addr = ram_we ? bank_address[BANK_AW-1:0]
                             : (start_reg[BANK_AW-1:0] + BANK_AW'(widx_reg));

    mbtcp_ram #(.WIDTH(16), .DEPTH(BANK_WORDS)) u_bank (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (bank_data),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strict_reg    <= 1'b0;
            own_unit_reg  <= 8'd1;
            max_count_reg <= 7'd125;
            bank_att_reg  <= 1'b1;
            pos_reg       <= '0;
            trans_reg     <= '0;
            proto_reg     <= '0;
            length_reg    <= '0;
            unit_reg      <= '0;
            func_reg      <= '0;
            start_reg     <= '0;
            count_reg     <= '0;
            hidx_reg      <= '0;
            widx_reg      <= '0;
            asm_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_close_reg <= 1'b0;
            out_data_reg  <= '0;
            out_bytes_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_STRICT:   strict_reg    <= cfg_data[0];
                    CFG_UNIT:     own_unit_reg  <= cfg_data;
                    CFG_MAXCOUNT: max_count_reg <= cfg_data[6:0];
                    CFG_BANK:     bank_att_reg  <= cfg_data[0];
                    default:      strict_reg    <= strict_reg;
                endcase
            end

            if (is_byte)
            begin
                pos_reg <= pos_inc[8:0];
                if (pos_reg < 9'd2)       trans_reg  <= {trans_reg[7:0], rx_byte};
                else if (pos_reg < 9'd4)  proto_reg  <= {proto_reg[7:0], rx_byte};
                else if (pos_reg < 9'd6)  length_reg <= {length_reg[7:0], rx_byte};
                else if (pos_reg == 9'd6) unit_reg   <= rx_byte;
                else if (pos_reg == 9'd7) func_reg   <= rx_byte;
                else if (pos_reg < 9'd10) start_reg  <= {start_reg[7:0], rx_byte};
                else if (pos_reg < 9'd12) count_reg  <= {count_reg[7:0], rx_byte};
            end

            if (cmd.push && (cmd.sel == SEL_HDR))
                hidx_reg <= hidx_reg + 4'd1;
            if (cmd.push && (cmd.sel == SEL_WLO))
                widx_reg <= widx_reg + 7'd1;

            if (ev_close || cmd.clear ||
                (in_fire && (req_type_t'(req_type) == REQ_CONN)))
            begin
                pos_reg    <= '0;
                trans_reg  <= '0;
                proto_reg  <= '0;
                length_reg <= '0;
                unit_reg   <= '0;
                func_reg   <= '0;
                start_reg  <= '0;
                count_reg  <= '0;
                hidx_reg   <= '0;
                widx_reg   <= '0;
            end

            if (flush)
            begin
                asm_reg  <= '0;
                fill_reg <= '0;
            end
            else if (cmd.push)
            begin
                asm_reg  <= asm_next;
                fill_reg <= fill_inc[2:0];
            end

            if (flush)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= asm_next;
                out_bytes_reg <= fill_inc;
                out_last_reg  <= cmd.last;
                out_close_reg <= 1'b0;
            end
            else if (cmd.close)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= '0;
                out_bytes_reg <= '0;
                out_last_reg  <= 1'b1;
                out_close_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.ev_close   = ev_close;
    assign status.ev_answer  = ev_answer;
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.is_exc     = (exc_code != EXC_NONE);
    assign status.hdr_done   = (hidx_reg == 4'd8);
    assign status.words_done = (widx_reg == (count_reg[6:0] - 7'd1));

    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign out_bytes  = out_bytes_reg;
    assign last_chunk = out_last_reg;
    assign close_conn = out_close_reg;

endmodule

FILE: rtl/core/modbus_tcp_read_holding_server.sv
// Top level of the Modbus TCP holding register read server (function 0x03).
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   req_type, rx_byte, bank_address, bank_data
//   out      output     out_valid / out_ready out_data, out_bytes, last_chunk, close_conn
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// A stream byte, bank write or new connection transaction that does not end a frame
// leaves the block ready for the next one. A bad MBAP header first hands out a close
// result. A complete request is answered byte by byte into 8-byte chunks: the nine
// header and function bytes, then per register word a read of the single bank port
// and its two bytes; an exception answer ends after the header. A stall on the output
// holds the sequencer; the input waits only while a close result or a response is
// being handed out.
// After reset, the configuration holds strict off, unit id 1, max count 125 and
// the bank attached; the bank contents are undefined until written.
module modbus_tcp_read_holding_server
    import mbtcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [7:0]  rx_byte,
    input  logic [15:0] bank_address,
    input  logic [15:0] bank_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_data,
    output logic [3:0]  out_bytes,
    output logic        last_chunk,
    output logic        close_conn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    mbtcp_cmd_t    cmd;
    mbtcp_status_t status;
    logic          in_fire;

    // An input transaction completes when both sides of the handshake agree.
    assign in_fire = in_valid && in_ready;

    mbtcp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .status   (status),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    mbtcp_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .req_type     (req_type),
        .rx_byte      (rx_byte),
        .bank_address (bank_address),
        .bank_data    (bank_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .out_data     (out_data),
        .out_bytes    (out_bytes),
        .last_chunk   (last_chunk),
        .close_conn   (close_conn)
    );

endmodule

FILE: rtl/core/mbtcp_checker.sv
// Port level checks of the server output and their bind to the top level.
module mbtcp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] out_data,
    input logic [3:0]  out_bytes,
    input logic        last_chunk,
    input logic        close_conn
);

    a_close_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && close_conn) |-> (out_bytes == 4'd0) && last_chunk && (out_data == 64'd0))
        else $error("close result malformed");

    a_chunk_size: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !close_conn) |-> (out_bytes != 4'd0) && (out_bytes <= 4'd8))
        else $error("chunk byte count out of range");

    a_full_middle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_chunk) |-> (out_bytes == 4'd8))
        else $error("non final chunk not full");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_data))
        else $error("stalled output changed");

endmodule

bind modbus_tcp_read_holding_server mbtcp_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .out_bytes  (out_bytes),
    .last_chunk (last_chunk),
    .close_conn (close_conn)
);

FILE: tb/tb.sv
// Self-checking testbench for the Modbus TCP holding register read server.
`timescale 1ns / 100ps

module tb;
    import mbtcp_pkg::*;

    // Clock, reset and the ports of the block under test.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type = REQ_BYTE;
    logic [7:0]  rx_byte = 8'h00;
    logic [15:0] bank_address = 16'h0000;
    logic [15:0] bank_data = 16'h0000;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] out_data;
    logic [3:0]  out_bytes;
    logic        last_chunk;
    logic        close_conn;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_STRICT;
    logic [7:0]  cfg_data = 8'h00;

    // One expected output chunk.
    typedef struct {
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        last;
        logic        close;
    } chunk_t;

    chunk_t chunk_q[$];

    // Private copy of the server state used to work out the expected chunks.
    logic        m_strict;
    logic [7:0]  m_unit_id;
    logic [6:0]  m_max_count;
    logic        m_bank_on;
    logic [8:0]  m_pos;
    logic [15:0] m_trans;
    logic [15:0] m_proto;
    logic [15:0] m_len;
    logic [7:0]  m_unit;
    logic [7:0]  m_func;
    logic [15:0] m_start;
    logic [15:0] m_count;
    logic [15:0] m_bank [BANK_WORDS];

    int errors = 0;
    int n_items = 0;
    int n_chunks = 0;
    int n_closes = 0;
    int n_reads = 0;
    int n_excs = 0;

    // Receiver stall pattern: a 16-bit mask that rotates every cycle and is
    // swapped for a new one now and then; the all-ones mask gives stall-free spells.
    logic [15:0] stall_mask = 16'hFFFF;

    modbus_tcp_read_holding_server u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .rx_byte      (rx_byte),
        .bank_address (bank_address),
        .bank_data    (bank_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .out_bytes    (out_bytes),
        .last_chunk   (last_chunk),
        .close_conn   (close_conn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void clear_frame();
        m_pos = '0;
        m_trans = '0;
        m_proto = '0;
        m_len = '0;
        m_unit = '0;
        m_func = '0;
        m_start = '0;
        m_count = '0;
    endfunction

    // Cuts a response byte string into 8-byte chunks and queues them.
    function automatic void split_chunks(input logic [7:0] resp[$]);
        chunk_t c;
        int     n;
        n = resp.size();
        for (int k = 0; k < n; k += 8)
        begin
            c.data = '0;
            for (int i = 0; i < 8; i++)
            begin
                c.data = c.data << 8;
                if (k + i < n)
                    c.data[7:0] = resp[k + i];
            end
            c.nbytes = (n - k > 8) ? 4'd8 : 4'(n - k);
            c.last = (k + 8 >= n);
            c.close = 1'b0;
            chunk_q = {chunk_q, c};
        end
    endfunction

    // Builds the answer to a complete request, exception or normal read.
    function automatic void answer_request();
        logic [7:0]  resp[$];
        logic [7:0]  code;
        logic [16:0] end_addr;
        int          plen;
        code = EXC_NONE;
        end_addr = 17'(m_start) + 17'(m_count);
        if (m_strict && m_unit != m_unit_id)
            code = EXC_GATEWAY;
        else if (m_func != FUNC_READ_HOLDING)
            code = EXC_ILLEGAL_FUNC;
        else if (m_len != 16'd6)
            code = EXC_ILLEGAL_VALUE;
        else if (m_count == 0 || m_count > 16'(m_max_count))
            code = EXC_ILLEGAL_VALUE;
        else if (end_addr > 17'd65536)
            code = EXC_ILLEGAL_ADDR;
        else if (!m_bank_on)
            code = EXC_DEVICE_FAIL;
        else if (end_addr > 17'(BANK_WORDS))
            code = EXC_ILLEGAL_ADDR;
        if (code != EXC_NONE)
        begin
            resp = {resp, m_func | EXC_FLAG, code};
            n_excs++;
        end
        else
        begin
            resp = {resp, FUNC_READ_HOLDING, 8'(m_count * 2)};
            for (int i = 0; i < m_count; i++)
            begin
                resp = {resp, m_bank[m_start + i][15:8], m_bank[m_start + i][7:0]};
            end
            n_reads++;
        end
        plen = resp.size() + 1;
        resp = {m_trans[15:8], m_trans[7:0], 8'h00, 8'h00, 8'(plen >> 8), 8'(plen),
                m_unit, resp};
        split_chunks(resp);
    endfunction

    // Advances the prediction by one accepted transaction.
    function automatic void predict_item(input logic [1:0] kind, input logic [7:0] b,
                                         input logic [15:0] addr, input logic [15:0] data);
        logic [8:0] pos;
        chunk_t     c;
        if (kind == REQ_WRITE)
        begin
            if (addr < BANK_WORDS)
                m_bank[addr] = data;
            return;
        end
        if (kind == REQ_CONN)
        begin
            clear_frame();
            return;
        end
        if (kind != REQ_BYTE)
            return;
        pos = m_pos;
        if (pos < 2)       m_trans = {m_trans[7:0], b};
        else if (pos < 4)  m_proto = {m_proto[7:0], b};
        else if (pos < 6)  m_len = {m_len[7:0], b};
        else if (pos == 6) m_unit = b;
        else if (pos == 7) m_func = b;
        else if (pos < 10) m_start = {m_start[7:0], b};
        else if (pos < 12) m_count = {m_count[7:0], b};
        m_pos = pos + 9'd1;
        if (pos == HDR_LAST)
        begin
            if (m_proto != 0 || m_len < 2 || m_len > MAX_LENGTH)
            begin
                c.data = '0;
                c.nbytes = '0;
                c.last = 1'b1;
                c.close = 1'b1;
                chunk_q = {chunk_q, c};
                n_closes++;
                clear_frame();
            end
        end
        else if (pos > HDR_LAST && 32'(pos) + 1 >= 6 + 32'(m_len))
        begin
            answer_request();
            clear_frame();
        end
    endfunction

    // Sends one transaction, with a possible random gap first when the burst is spent.
    // Valid stays high between back to back transactions of a burst.
    int burst_left = 0;
    task automatic send_item(input logic [1:0] kind, input logic [7:0] b,
                             input logic [15:0] addr, input logic [15:0] data);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        req_type <= kind;
        rx_byte <= b;
        bank_address <= addr;
        bank_data <= data;
        do @(posedge clk); while (!in_ready);
        predict_item(kind, b, addr, data);
        n_items++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(REQ_BYTE, b, 16'($urandom), 16'($urandom));
    endtask

    // A full ADU with the given header and PDU fields; extra bytes pad the PDU.
    task automatic send_adu(input logic [15:0] trans, input logic [15:0] proto,
                            input logic [15:0] len, input logic [7:0] unit,
                            input logic [7:0] func, input logic [15:0] start,
                            input logic [15:0] count);
        logic [7:0] pdu[12];
        pdu = '{trans[15:8], trans[7:0], proto[15:8], proto[7:0], len[15:8], len[7:0],
                unit, func, start[15:8], start[7:0], count[15:8], count[7:0]};
        for (int i = 0; i < 6 + len; i++)
        begin
            send_byte(i < 12 ? pdu[i] : 8'($urandom));
            // A bad header ends the frame at the unit id byte.
            if (i == HDR_LAST && (proto != 0 || len < 2 || len > MAX_LENGTH))
                break;
        end
    endtask

    task automatic read_request(input logic [15:0] start, input logic [15:0] count);
        send_adu(16'($urandom), 16'h0000, 16'd6, m_unit_id, FUNC_READ_HOLDING, start, count);
    endtask

    // Drops valid, then waits for every expected chunk plus a drain margin.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (chunk_q.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_cfg(input cfg_index_t idx, input logic [7:0] value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_STRICT:   m_strict = value[0];
            CFG_UNIT:     m_unit_id = value;
            CFG_MAXCOUNT: m_max_count = value[6:0];
            CFG_BANK:     m_bank_on = value[0];
            default:      ;
        endcase
    endtask

    // Fills the first part of the bank and its last words, so reads stay on written words.
    task automatic test_bank_fill();
        send_item(REQ_WRITE, 8'h00, 16'h0000, 16'hFFFF);
        send_item(REQ_WRITE, 8'h00, 16'h0001, 16'h0000);
        for (int a = 2; a < 128; a++)
            send_item(REQ_WRITE, 8'($urandom), 16'(a), 16'($urandom));
        for (int a = BANK_WORDS - 8; a < BANK_WORDS; a++)
            send_item(REQ_WRITE, 8'($urandom), 16'(a), 16'($urandom));
        // Out of range writes are dropped, and the unknown request type is ignored.
        send_item(REQ_WRITE, 8'h00, 16'hFFFF, 16'h1234);
        send_item(REQ_WRITE, 8'h00, 16'(BANK_WORDS), 16'h5678);
        send_item(REQ_NONE, 8'hFF, 16'hFFFF, 16'hFFFF);
    endtask

    // Normal reads, the illegal function, value and address answers and the header checks, with the reset settings.
    task automatic test_directed();
        read_request(16'd0, 16'd1);
        read_request(16'd0, 16'd125);
        read_request(16'(BANK_WORDS - 8), 16'd8);
        send_adu(16'hFFFF, 16'h0000, 16'd6, 8'hFF, 8'h04, 16'd0, 16'd1);
        send_adu(16'h0001, 16'h0000, 16'd2, 8'h01, 8'h03, 16'd0, 16'd1);
        send_adu(16'h0002, 16'h0000, 16'd9, 8'h01, 8'h03, 16'd0, 16'd2);
        read_request(16'd0, 16'd0);
        read_request(16'd0, 16'd126);
        read_request(16'hFFFF, 16'd2);
        read_request(16'(BANK_WORDS - 1), 16'd2);
        send_adu(16'h0003, 16'h0001, 16'd6, 8'h01, 8'h03, 16'd0, 16'd1);
        send_adu(16'h0004, 16'h8000, 16'd6, 8'h01, 8'h03, 16'd0, 16'd1);
        send_adu(16'h0005, 16'h0000, 16'd1, 8'h01, 8'h03, 16'd0, 16'd1);
        send_adu(16'h0006, 16'h0000, 16'd0, 8'h01, 8'h03, 16'd0, 16'd1);
        send_adu(16'h0007, 16'h0000, 16'd255, 8'h01, 8'h03, 16'd0, 16'd1);
        send_adu(16'h0008, 16'h0000, 16'd20, 8'h01, 8'h03, 16'd0, 16'd1);
        // A new connection in the middle of a frame drops the partial request.
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h00);
        send_item(REQ_CONN, 8'h00, 16'h0000, 16'h0000);
        read_request(16'd5, 16'd3);
    endtask

    // Strict unit check, unit id and count limit extremes, and the detached bank.
    task automatic test_config();
        write_cfg(CFG_STRICT, 8'h01);
        write_cfg(CFG_UNIT, 8'hFF);
        read_request(16'd0, 16'd2);
        send_adu(16'h0010, 16'h0000, 16'd6, 8'h00, 8'h03, 16'd0, 16'd2);
        write_cfg(CFG_UNIT, 8'h00);
        read_request(16'd1, 16'd4);
        send_adu(16'h0011, 16'h0000, 16'd6, 8'hFF, 8'h03, 16'd0, 16'd2);
        write_cfg(CFG_MAXCOUNT, 8'h01);
        read_request(16'd0, 16'd1);
        read_request(16'd0, 16'd2);
        write_cfg(CFG_BANK, 8'h00);
        read_request(16'd0, 16'd1);
        read_request(16'hFFFF, 16'd1);
        write_cfg(CFG_BANK, 8'h01);
        write_cfg(CFG_STRICT, 8'h00);
        write_cfg(CFG_MAXCOUNT, 8'h7D);
    endtask

    // Mostly well-formed requests with random content, plus noise and broken frames.
    task automatic test_random(input int budget);
        int          pick;
        logic [15:0] start;
        logic [15:0] count;
        while (n_items < budget)
        begin
            pick = $urandom_range(0, 99);
            count = 16'($urandom_range(1, 12));
            start = 16'($urandom_range(0, 128 - count));
            if (pick < 55)
                read_request(start, count);
            else if (pick < 65)
                // Large counts start near zero so that reads stay on written words.
                send_adu(16'($urandom), 16'h0000, 16'($urandom_range(2, 12)),
                         8'($urandom), 8'($urandom_range(0, 4)),
                         16'($urandom_range(0, 2)), 16'($urandom_range(0, 130)));
            else if (pick < 72)
                send_adu(16'($urandom), 16'($urandom), 16'($urandom),
                         8'($urandom), 8'h03, start, count);
            else if (pick < 82)
                send_item(REQ_WRITE, 8'($urandom), 16'($urandom_range(0, 127)),
                          16'($urandom));
            else if (pick < 87)
                send_item(REQ_WRITE, 8'($urandom), 16'($urandom), 16'($urandom));
            else if (pick < 92)
                send_item(REQ_CONN, 8'($urandom), 16'($urandom), 16'($urandom));
            else
            begin
                // A truncated frame cut off by a new connection.
                repeat ($urandom_range(1, 10)) send_byte(8'($urandom));
                send_item(REQ_CONN, 8'($urandom), 16'($urandom), 16'($urandom));
            end
        end
    endtask

    // Receiver: stalls on its own pattern and checks each chunk against the queue.
    always @(posedge clk)
    begin
        chunk_t want;
        if (rst_n)
        begin
            if ($urandom_range(0, 63) == 0)
                stall_mask <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
            else
                stall_mask <= {stall_mask[14:0], stall_mask[15]};
            out_ready <= stall_mask[15];
            if (out_valid && out_ready)
            begin
                n_chunks++;
                if (chunk_q.size() == 0)
                begin
                    $display("%0t: unexpected chunk data=%h bytes=%0d", $time, out_data,
                             out_bytes);
                    errors++;
                end
                else
                begin
                    want = chunk_q.pop_front();
                    if (out_data !== want.data)
                    begin
                        $display("%0t: out_data expected %h actual %h", $time, want.data,
                                 out_data);
                        errors++;
                    end
                    if (out_bytes !== want.nbytes)
                    begin
                        $display("%0t: out_bytes expected %0d actual %0d", $time,
                                 want.nbytes, out_bytes);
                        errors++;
                    end
                    if (last_chunk !== want.last)
                    begin
                        $display("%0t: last_chunk expected %b actual %b", $time, want.last,
                                 last_chunk);
                        errors++;
                    end
                    if (close_conn !== want.close)
                    begin
                        $display("%0t: close_conn expected %b actual %b", $time, want.close,
                                 close_conn);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        m_strict = 1'b0;
        m_unit_id = 8'd1;
        m_max_count = 7'd125;
        m_bank_on = 1'b1;
        clear_frame();
        for (int i = 0; i < BANK_WORDS; i++)
            m_bank[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_bank_fill();
        test_directed();
        test_config();
        test_random(n_items + 15);
        // A few closing passes with odd settings reached during random traffic.
        write_cfg(CFG_STRICT, 8'h01);
        write_cfg(CFG_UNIT, 8'h01);
        test_random(n_items + 10);
        write_cfg(CFG_MAXCOUNT, 8'h05);
        test_random(n_items + 10);
        wait_idle();
        $display("Sent %0d transactions; checked %0d chunks (%0d reads, %0d exceptions,",
                 n_items, n_chunks, n_reads, n_excs);
        $display("%0d header closes) across several configuration settings.", n_closes);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/mbtcp_pkg.sv
rtl/core/mbtcp_ram.sv
rtl/core/mbtcp_ctrl.sv
rtl/core/mbtcp_dp.sv
rtl/core/modbus_tcp_read_holding_server.sv
rtl/core/mbtcp_checker.sv
tb/tb.sv
